// ----- design/alubs_pkg.sv -----
// Shared types and codes for the data-processing ALU with barrel shifter.
// Used by alubs_shifter, alubs_exec and alu_with_barrel_shifter_flags_core.
package alubs_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned AmtW   = 8;
    localparam int unsigned InW    = 80;
    localparam int unsigned OutW   = 40;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_kind_t;

    // Condition flags, N in the top bit down to V
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // One input word after unpacking
    typedef struct packed {
        logic        update_flags;
        logic        amount_from_register;
        logic [AmtW-1:0]  shift_amount;
        shift_kind_t shift_kind;
        logic [WordW-1:0] operand_base;
        logic [WordW-1:0] operand_first;
        opcode_t     operation;
    } item_t;

    // Shifter output handed to the execute unit
    typedef struct packed {
        logic [WordW-1:0] operand;
        logic             carry;
    } shift_out_t;

endpackage

// ----- design/alubs_shifter.sv -----
// Barrel shifter: LSL, LSR, ASR, ROR and RRX with shifter carry-out.
// Depends on alubs_pkg.
module alubs_shifter (
    input  alubs_pkg::shift_kind_t          shift_kind,
    input  logic [alubs_pkg::AmtW-1:0]      shift_amount,
    input  logic                            amount_from_register,
    input  logic [alubs_pkg::WordW-1:0]     operand_base,
    input  logic                            carry_in,
    output alubs_pkg::shift_out_t           shift_out
);

    logic        amt_zero;
    logic        amt_below32;
    logic        amt_is32;
    logic [4:0]  sh_dist;
    logic [32:0] lsl_wide;
    logic [32:0] lsr_wide;
    logic [32:0] asr_wide;
    logic [63:0] ror_wide;

    // Decode the distance; an immediate zero means 32 for LSR and ASR
    assign amt_zero    = (shift_amount == '0);
    assign amt_below32 = !amt_zero && (shift_amount < 8'd32);
    assign amt_is32    = (shift_amount == 8'd32) || amt_zero;
    assign sh_dist     = shift_amount[4:0];

    // Shift one bit wider so the last bit shifted out is the carry
    assign lsl_wide = {1'b0, operand_base} << sh_dist;
    assign lsr_wide = {operand_base, 1'b0} >> sh_dist;
    assign asr_wide = 33'($signed({operand_base, 1'b0}) >>> sh_dist);
    assign ror_wide = {operand_base, operand_base} >> sh_dist;

    // Select by kind and range
    always_comb
    begin
        shift_out.operand = operand_base;
        shift_out.carry   = carry_in;
        if (amt_zero && (amount_from_register || shift_kind == alubs_pkg::SH_LSL))
        begin
            shift_out.operand = operand_base;
            shift_out.carry   = carry_in;
        end
        else if (amt_zero && shift_kind == alubs_pkg::SH_ROR)
        begin
            shift_out.operand = {carry_in, operand_base[31:1]};
            shift_out.carry   = operand_base[0];
        end
        else
        begin
            unique case (shift_kind)
                alubs_pkg::SH_LSL:
                begin
                    if (amt_below32)
                    begin
                        shift_out.operand = lsl_wide[31:0];
                        shift_out.carry   = lsl_wide[32];
                    end
                    else
                    begin
                        shift_out.operand = '0;
                        shift_out.carry   = amt_is32 ? operand_base[0] : 1'b0;
                    end
                end
                alubs_pkg::SH_LSR:
                begin
                    if (amt_below32)
                    begin
                        shift_out.operand = lsr_wide[32:1];
                        shift_out.carry   = lsr_wide[0];
                    end
                    else
                    begin
                        shift_out.operand = '0;
                        shift_out.carry   = amt_is32 ? operand_base[31] : 1'b0;
                    end
                end
                alubs_pkg::SH_ASR:
                begin
                    if (amt_below32)
                    begin
                        shift_out.operand = asr_wide[32:1];
                        shift_out.carry   = asr_wide[0];
                    end
                    else
                    begin
                        shift_out.operand = {32{operand_base[31]}};
                        shift_out.carry   = operand_base[31];
                    end
                end
                alubs_pkg::SH_ROR:
                begin
                    // a multiple of 32 leaves the word as is; carry is bit 31 either way
                    shift_out.operand = ror_wide[31:0];
                    shift_out.carry   = ror_wide[31];
                end
                default:
                begin
                    shift_out.operand = operand_base;
                    shift_out.carry   = carry_in;
                end
            endcase
        end
    end

endmodule

// ----- design/alubs_exec.sv -----
// Data-processing unit: logical ops, shared adder and NZCV update.
// Depends on alubs_pkg.
module alubs_exec (
    input  alubs_pkg::opcode_t              operation,
    input  logic [alubs_pkg::WordW-1:0]     operand_first,
    input  alubs_pkg::shift_out_t           shift_out,
    input  logic                            update_flags,
    input  alubs_pkg::flags_t               flags_cur,
    output logic [alubs_pkg::WordW-1:0]     result_value,
    output logic                            write_result,
    output alubs_pkg::flags_t               flags_new
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] add_sum;
    logic        add_v;
    logic        arith;

    assign a = operand_first;
    assign b = shift_out.operand;

    // Steer operands into the single adder
    always_comb
    begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        arith   = 1'b1;
        unique case (operation)
            alubs_pkg::OP_SUB, alubs_pkg::OP_CMP:
            begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            alubs_pkg::OP_RSB:
            begin
                add_x   = b;
                add_y   = ~a;
                add_cin = 1'b1;
            end
            alubs_pkg::OP_ADD, alubs_pkg::OP_CMN:
            begin
                add_cin = 1'b0;
            end
            alubs_pkg::OP_ADC:
            begin
                add_cin = flags_cur.c;
            end
            alubs_pkg::OP_SBC:
            begin
                add_y   = ~b;
                add_cin = flags_cur.c;
            end
            alubs_pkg::OP_RSC:
            begin
                add_x   = b;
                add_y   = ~a;
                add_cin = flags_cur.c;
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v   = (add_x[31] ^ add_sum[31]) & (add_y[31] ^ add_sum[31]);

    // Pick the result word
    always_comb
    begin
        unique case (operation)
            alubs_pkg::OP_AND, alubs_pkg::OP_TST: result_value = a & b;
            alubs_pkg::OP_EOR, alubs_pkg::OP_TEQ: result_value = a ^ b;
            alubs_pkg::OP_ORR:                    result_value = a | b;
            alubs_pkg::OP_MOV:                    result_value = b;
            alubs_pkg::OP_BIC:                    result_value = a & ~b;
            alubs_pkg::OP_MVN:                    result_value = ~b;
            default:                              result_value = add_sum[31:0];
        endcase
    end

    // Compare and test ops only set flags
    assign write_result = !(operation == alubs_pkg::OP_TST || operation == alubs_pkg::OP_TEQ
                            || operation == alubs_pkg::OP_CMP
                            || operation == alubs_pkg::OP_CMN);

    // Update NZCV; logical ops keep V and take C from the shifter
    always_comb
    begin
        flags_new = flags_cur;
        if (update_flags)
        begin
            flags_new.n = result_value[31];
            flags_new.z = (result_value == '0);
            if (arith)
            begin
                flags_new.c = add_sum[32];
                flags_new.v = add_v;
            end
            else
            begin
                flags_new.c = shift_out.carry;
            end
        end
    end

endmodule

// ----- design/alu_with_barrel_shifter_flags_core.sv -----
// Top level of the data-processing ALU: input register, shifter, execute unit,
// flag register and output register. Depends on alubs_pkg, alubs_shifter, alubs_exec.
//
// Each word on s_t* carries one data-processing operation; one result word leaves
// on m_t* for each, in order. A taken word goes to the input register and then to
// the output register that drives m_t*; a new word is taken every cycle while
// the output is drained: the work sits in one combinational pass from the input
// register through the barrel shifter and adder into the output register, and the
// NZCV register is updated in that same pass so the next word sees the new flags.
// The flags leave reset at zero. s_tready is combinational in m_tready: it drops
// only while both register stages hold a word and m_tready is low.
module alu_with_barrel_shifter_flags_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // fields from bit 0: operation[3:0], operand_first[31:0], operand_base[31:0],
    // shift_kind[1:0], shift_amount[7:0], amount_from_register, update_flags
    input  logic [alubs_pkg::InW-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // fields from bit 0: result_value[31:0], write_result, negative_flag,
    // zero_flag, carry_flag, overflow_flag, zero pad[2:0]
    output logic [alubs_pkg::OutW-1:0]  m_tdata
);

    alubs_pkg::item_t      item_reg;
    logic                  in_valid_reg;
    alubs_pkg::flags_t     flags_reg;
    alubs_pkg::flags_t     flags_next;
    logic                  out_valid_reg;
    logic [31:0]           result_reg;
    logic                  write_reg;
    alubs_pkg::flags_t     out_flags_reg;

    alubs_pkg::shift_out_t shift_out;
    logic [31:0]           result_next;
    logic                  write_next;
    logic                  out_free;
    logic                  advance;
    logic                  in_take;

    // Handshake between the two stages
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= alubs_pkg::item_t'(s_tdata);
        end
    end

    alubs_shifter u_shifter (
        .shift_kind           (item_reg.shift_kind),
        .shift_amount         (item_reg.shift_amount),
        .amount_from_register (item_reg.amount_from_register),
        .operand_base         (item_reg.operand_base),
        .carry_in             (flags_reg.c),
        .shift_out            (shift_out)
    );

    alubs_exec u_exec (
        .operation     (item_reg.operation),
        .operand_first (item_reg.operand_first),
        .shift_out     (shift_out),
        .update_flags  (item_reg.update_flags),
        .flags_cur     (flags_reg),
        .result_value  (result_next),
        .write_result  (write_next),
        .flags_new     (flags_next)
    );

    // Flag register: advance with each word leaving the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg    <= result_next;
            write_reg     <= write_next;
            out_flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_flags_reg.v, out_flags_reg.c, out_flags_reg.z,
                       out_flags_reg.n, write_reg, result_reg};

    // The presented word always carries the flags currently held
    a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_flags_reg == flags_reg))
        else $error("output flags differ from flag register");

    // Flags move only when a word passes to the output
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without a word advancing");

    // A word without a flag update leaves NZCV untouched
    a_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !item_reg.update_flags) |=> $stable(flags_reg))
        else $error("flags changed on a word that does not set them");

    // A full input stage blocked downstream must refuse new words
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

endmodule

// ----- sim/alubs_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the data-processing ALU: watches both stream channels, predicts
// each result word with its own shifter/adder/flag model and compares. Needs alubs_pkg.
module alubs_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [alubs_pkg::InW-1:0]   s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [alubs_pkg::OutW-1:0]  m_tdata,
    output int                          mismatch_count,
    output int                          pending_count
);

    typedef struct packed {
        logic [alubs_pkg::WordW-1:0] value;
        logic                        write;
        alubs_pkg::flags_t           flags;
    } alu_word_t;

    alu_word_t         pending_results[$];
    alubs_pkg::flags_t nzcv;

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        mismatch_count++;
    endtask

    // Barrel shifter with the immediate-zero encodings (shift by 32, RRX)
    function automatic logic [31:0] barrel_shift(input alubs_pkg::shift_kind_t kind,
                                                 input logic [31:0] base,
                                                 input logic [7:0] amount,
                                                 input logic from_reg,
                                                 input logic carry_in,
                                                 output logic carry_out);
        logic [8:0]  sh_dist;
        logic [4:0]  rot;
        logic [31:0] res;
        sh_dist = {1'b0, amount};
        rot = amount[4:0];
        res = base;
        carry_out = carry_in;
        if (amount == 8'd0 && (from_reg || kind == alubs_pkg::SH_LSL))
        begin
            res = base;
            carry_out = carry_in;
        end
        else if (amount == 8'd0 && kind == alubs_pkg::SH_ROR)
        begin
            res = {carry_in, base[31:1]};
            carry_out = base[0];
        end
        else
        begin
            if (amount == 8'd0)
                sh_dist = 9'd32;
            unique case (kind)
                alubs_pkg::SH_LSL:
                begin
                    if (sh_dist < 9'd32)
                    begin
                        carry_out = base[32 - sh_dist];
                        res = base << sh_dist;
                    end
                    else
                    begin
                        carry_out = (sh_dist == 9'd32) ? base[0] : 1'b0;
                        res = '0;
                    end
                end
                alubs_pkg::SH_LSR:
                begin
                    if (sh_dist < 9'd32)
                    begin
                        carry_out = base[sh_dist - 1];
                        res = base >> sh_dist;
                    end
                    else
                    begin
                        carry_out = (sh_dist == 9'd32) ? base[31] : 1'b0;
                        res = '0;
                    end
                end
                alubs_pkg::SH_ASR:
                begin
                    if (sh_dist < 9'd32)
                    begin
                        carry_out = base[sh_dist - 1];
                        res = $signed(base) >>> sh_dist;
                    end
                    else
                    begin
                        carry_out = base[31];
                        res = {32{base[31]}};
                    end
                end
                default:
                begin
                    if (rot == 5'd0)
                    begin
                        carry_out = base[31];
                        res = base;
                    end
                    else
                    begin
                        carry_out = base[rot - 1];
                        res = (base >> rot) | (base << (6'd32 - rot));
                    end
                end
            endcase
        end
        return res;
    endfunction

    // x + y + cin with carry out and signed overflow
    function automatic logic [31:0] add_carry(input logic [31:0] x, input logic [31:0] y,
                                              input logic cin, output logic c,
                                              output logic v);
        logic [32:0] sum;
        sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
        c = sum[32];
        v = (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
        return sum[31:0];
    endfunction

    function automatic alu_word_t predict_alu(input alubs_pkg::item_t w,
                                              input alubs_pkg::flags_t cur);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic        sc;
        logic        c;
        logic        v;
        logic        arith;
        alu_word_t   e;
        a = w.operand_first;
        b = barrel_shift(w.shift_kind, w.operand_base, w.shift_amount,
                         w.amount_from_register, cur.c, sc);
        c = 1'b0;
        v = 1'b0;
        unique case (w.operation)
            alubs_pkg::OP_SUB, alubs_pkg::OP_RSB, alubs_pkg::OP_ADD, alubs_pkg::OP_ADC,
            alubs_pkg::OP_SBC, alubs_pkg::OP_RSC, alubs_pkg::OP_CMP, alubs_pkg::OP_CMN:
                arith = 1'b1;
            default:
                arith = 1'b0;
        endcase
        unique case (w.operation)
            alubs_pkg::OP_AND, alubs_pkg::OP_TST: r = a & b;
            alubs_pkg::OP_EOR, alubs_pkg::OP_TEQ: r = a ^ b;
            alubs_pkg::OP_SUB, alubs_pkg::OP_CMP: r = add_carry(a, ~b, 1'b1, c, v);
            alubs_pkg::OP_RSB:                    r = add_carry(b, ~a, 1'b1, c, v);
            alubs_pkg::OP_ADD, alubs_pkg::OP_CMN: r = add_carry(a, b, 1'b0, c, v);
            alubs_pkg::OP_ADC:                    r = add_carry(a, b, cur.c, c, v);
            alubs_pkg::OP_SBC:                    r = add_carry(a, ~b, cur.c, c, v);
            alubs_pkg::OP_RSC:                    r = add_carry(b, ~a, cur.c, c, v);
            alubs_pkg::OP_ORR:                    r = a | b;
            alubs_pkg::OP_MOV:                    r = b;
            alubs_pkg::OP_BIC:                    r = a & ~b;
            default:                              r = ~b;
        endcase
        e.value = r;
        unique case (w.operation)
            alubs_pkg::OP_TST, alubs_pkg::OP_TEQ, alubs_pkg::OP_CMP, alubs_pkg::OP_CMN:
                e.write = 1'b0;
            default:
                e.write = 1'b1;
        endcase
        e.flags = cur;
        if (w.update_flags)
        begin
            e.flags.n = r[31];
            e.flags.z = (r == 32'd0);
            if (arith)
            begin
                e.flags.c = c;
                e.flags.v = v;
            end
            else
            begin
                e.flags.c = sc;
            end
        end
        return e;
    endfunction

    // Retire result words first, then queue the prediction for a newly taken word
    always @(posedge clk or negedge rst_n)
    begin
        alu_word_t want;
        alu_word_t got;
        if (!rst_n)
        begin
            nzcv = '0;
            pending_results.delete();
            pending_count = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.value   = m_tdata[31:0];
                got.write   = m_tdata[32];
                got.flags.n = m_tdata[33];
                got.flags.z = m_tdata[34];
                got.flags.c = m_tdata[35];
                got.flags.v = m_tdata[36];
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result word", 32'd0, got.value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("result_value", want.value, got.value);
                    if (got.write !== want.write)
                        report_mismatch("write_result", 32'(want.write), 32'(got.write));
                    if (got.flags.n !== want.flags.n)
                        report_mismatch("negative_flag", 32'(want.flags.n),
                                        32'(got.flags.n));
                    if (got.flags.z !== want.flags.z)
                        report_mismatch("zero_flag", 32'(want.flags.z), 32'(got.flags.z));
                    if (got.flags.c !== want.flags.c)
                        report_mismatch("carry_flag", 32'(want.flags.c), 32'(got.flags.c));
                    if (got.flags.v !== want.flags.v)
                        report_mismatch("overflow_flag", 32'(want.flags.v),
                                        32'(got.flags.v));
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_alu(alubs_pkg::item_t'(s_tdata), nzcv);
                nzcv = want.flags;
                pending_results.push_back(want);
            end
            pending_count = pending_results.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the ALU testbench: clock, reset, directed and random operation words,
// random back-pressure and the verdict. Needs alubs_pkg, alubs_checker and the core.
module tb_top;

    localparam int StallLimit = 5000;
    localparam int RandomPerPhase = 500;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [alubs_pkg::InW-1:0]   s_tdata = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [alubs_pkg::OutW-1:0]  m_tdata;
    int                          mismatch_count;
    int                          pending_count;
    int                          send_idle_pct = 23;
    int                          recv_idle_pct = 85;

    alu_with_barrel_shifter_flags_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alubs_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Random back-pressure on the result side
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if no word moves on either side for too long
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic alubs_pkg::item_t make_word(input alubs_pkg::opcode_t op,
                                                   input logic [31:0] a,
                                                   input logic [31:0] b,
                                                   input alubs_pkg::shift_kind_t kind,
                                                   input logic [7:0] amount,
                                                   input logic from_reg,
                                                   input logic setf);
        alubs_pkg::item_t w;
        w.operation            = op;
        w.operand_first        = a;
        w.operand_base         = b;
        w.shift_kind           = kind;
        w.shift_amount         = amount;
        w.amount_from_register = from_reg;
        w.update_flags         = setf;
        return w;
    endfunction

    // Lean on the corner values that stress carry and overflow
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // In-range distances as the largest share, with zero, 32 and beyond mixed in
    function automatic logic [7:0] pick_amount();
        case ($urandom_range(9))
            0, 1:    return 8'd0;
            2:       return 8'd32;
            3:       return 8'($urandom_range(7) * 32);
            4, 5:    return 8'($urandom_range(255));
            default: return 8'($urandom_range(31, 1));
        endcase
    endfunction

    function automatic alubs_pkg::item_t random_word();
        return make_word(alubs_pkg::opcode_t'($urandom_range(15)), pick_operand(),
                         pick_operand(), alubs_pkg::shift_kind_t'($urandom_range(3)),
                         pick_amount(), 1'($urandom_range(1)), ($urandom_range(3) != 0));
    endfunction

    // Offer one word, idling first at random, and hold until it is taken
    task automatic send_word(input alubs_pkg::item_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every opcode, operand extremes and the shifter corner encodings
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h0, alubs_pkg::SH_LSL,
                            8'd0, 1'b0, 1'b1));
        send_word(make_word(alubs_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h1, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_ADC, 32'h7FFF_FFFF, 32'h0, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_SUB, 32'h8000_0000, 32'h1, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_RSB, 32'h1, 32'h0, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_SBC, 32'h0, 32'h0, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_RSC, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            alubs_pkg::SH_LSL, 8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_TST, 32'hFFFF_FFFF, 32'h8000_0000,
                            alubs_pkg::SH_LSL, 8'd1, 1'b0, 1'b1));
        // immediate LSR and ASR of zero act as a shift by 32
        send_word(make_word(alubs_pkg::OP_TEQ, 32'h0, 32'hFFFF_FFFF, alubs_pkg::SH_LSR,
                            8'd0, 1'b0, 1'b1));
        send_word(make_word(alubs_pkg::OP_CMP, 32'h5, 32'h5, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_CMN, 32'h8000_0000, 32'h8000_0000,
                            alubs_pkg::SH_LSL, 8'd0, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_ORR, 32'h0, 32'h8000_0000, alubs_pkg::SH_ASR,
                            8'd0, 1'b0, 1'b1));
        // rotate through carry
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h1, alubs_pkg::SH_ROR,
                            8'd0, 1'b0, 1'b1));
        send_word(make_word(alubs_pkg::OP_BIC, 32'hFFFF_FFFF, 32'hF0, alubs_pkg::SH_LSL,
                            8'd4, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MVN, 32'h0, 32'h0, alubs_pkg::SH_LSL,
                            8'd0, 1'b1, 1'b1));
        // shifts of 32 and beyond
        send_word(make_word(alubs_pkg::OP_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            alubs_pkg::SH_LSL, 8'd32, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_EOR, 32'h1, 32'hFFFF_FFFF, alubs_pkg::SH_LSL,
                            8'd33, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h8000_0000, alubs_pkg::SH_LSR,
                            8'd32, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'hFFFF_FFFF, alubs_pkg::SH_LSR,
                            8'd255, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h8000_0001, alubs_pkg::SH_ASR,
                            8'd40, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h7FFF_FFFF, alubs_pkg::SH_ASR,
                            8'd255, 1'b0, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h8000_0000, alubs_pkg::SH_ROR,
                            8'd32, 1'b1, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h7FFF_FFFF, alubs_pkg::SH_ROR,
                            8'd64, 1'b0, 1'b1));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h0000_001F, alubs_pkg::SH_ROR,
                            8'd5, 1'b1, 1'b1));
        // flags held when not updated
        send_word(make_word(alubs_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            alubs_pkg::SH_LSL, 8'd0, 1'b1, 1'b0));
        send_word(make_word(alubs_pkg::OP_MOV, 32'h0, 32'h8000_0000, alubs_pkg::SH_ROR,
                            8'd0, 1'b1, 1'b0));

        // Random words under three back-pressure mixes
        for (int i = 0; i < RandomPerPhase; i++)
            send_word(random_word());
        send_idle_pct <= 85;
        recv_idle_pct <= 23;
        for (int i = 0; i < RandomPerPhase; i++)
            send_word(random_word());
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        for (int i = 0; i < RandomPerPhase; i++)
            send_word(random_word());
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/alubs_pkg.sv
design/alubs_shifter.sv
design/alubs_exec.sv
design/alu_with_barrel_shifter_flags_core.sv
sim/alubs_checker.sv
sim/tb_top.sv
